// ===== src/ktaf_pkg.sv =====
// Shared types, constants and the micro-op program of the tilt angle fuser.
`timescale 1ns / 1ps
`default_nettype none
package ktaf_pkg;

    localparam int KT_WORD_WIDTH = 48;
    localparam int KT_FRAC_BITS  = 32;
    localparam int CFG_W         = 32;
    localparam int CFG_ADDR_W    = 4;
    localparam int STEP_W        = 5;

    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 32'd12884902;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 32'd4294967;
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 32'd42949673;
    localparam logic [CFG_W-1:0] RST_PERIOD      = 32'd42949673;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ANGLE_NOISE = 4'd0,
        CFG_BIAS_NOISE  = 4'd1,
        CFG_MEAS_NOISE  = 4'd2,
        CFG_PERIOD      = 4'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu;

    typedef enum logic [4:0] {
        OPD_ANGLE, OPD_BIAS, OPD_P00, OPD_P01, OPD_P10, OPD_P11,
        OPD_MEAS, OPD_GYRO, OPD_QA, OPD_QG, OPD_RN, OPD_DT, OPD_ZERO,
        OPD_T0, OPD_T1, OPD_T2, OPD_T3, OPD_T4, OPD_T5, OPD_T6
    } t_opnd;

    typedef struct packed {
        t_alu  op;
        t_opnd a;
        t_opnd b;
        t_opnd d;
    } t_uop;

    typedef struct packed {
        logic             take_in;
        logic             start;
        logic             load_out;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_stat;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

    // One filter update: predict, covariance propagation, gains, correction.
    function automatic t_uop prog_rom(logic [STEP_W-1:0] idx);
        t_uop u;
        u = '{ALU_ADD, OPD_ZERO, OPD_ZERO, OPD_ZERO};
        case (idx)
            5'd0:  u = '{ALU_SUB, OPD_GYRO,  OPD_BIAS, OPD_T0};
            5'd1:  u = '{ALU_MUL, OPD_T0,    OPD_DT,   OPD_T0};
            5'd2:  u = '{ALU_ADD, OPD_ANGLE, OPD_T0,   OPD_ANGLE};
            5'd3:  u = '{ALU_SUB, OPD_QA,    OPD_P01,  OPD_T0};
            5'd4:  u = '{ALU_SUB, OPD_T0,    OPD_P10,  OPD_T0};
            5'd5:  u = '{ALU_SUB, OPD_ZERO,  OPD_P11,  OPD_T1};
            5'd6:  u = '{ALU_MUL, OPD_T0,    OPD_DT,   OPD_T0};
            5'd7:  u = '{ALU_ADD, OPD_P00,   OPD_T0,   OPD_P00};
            5'd8:  u = '{ALU_MUL, OPD_T1,    OPD_DT,   OPD_T1};
            5'd9:  u = '{ALU_ADD, OPD_P01,   OPD_T1,   OPD_P01};
            5'd10: u = '{ALU_ADD, OPD_P10,   OPD_T1,   OPD_P10};
            5'd11: u = '{ALU_MUL, OPD_QG,    OPD_DT,   OPD_T0};
            5'd12: u = '{ALU_ADD, OPD_P11,   OPD_T0,   OPD_P11};
            5'd13: u = '{ALU_SUB, OPD_MEAS,  OPD_ANGLE, OPD_T2};
            5'd14: u = '{ALU_ADD, OPD_RN,    OPD_P00,  OPD_T3};
            5'd15: u = '{ALU_DIV, OPD_P00,   OPD_T3,   OPD_T0};
            5'd16: u = '{ALU_DIV, OPD_P10,   OPD_T3,   OPD_T1};
            5'd17: u = '{ALU_MUL, OPD_T0,    OPD_P00,  OPD_T4};
            5'd18: u = '{ALU_MUL, OPD_T0,    OPD_P01,  OPD_T5};
            5'd19: u = '{ALU_MUL, OPD_T1,    OPD_P00,  OPD_T6};
            5'd20: u = '{ALU_MUL, OPD_T1,    OPD_P01,  OPD_T3};
            5'd21: u = '{ALU_SUB, OPD_P00,   OPD_T4,   OPD_P00};
            5'd22: u = '{ALU_SUB, OPD_P01,   OPD_T5,   OPD_P01};
            5'd23: u = '{ALU_SUB, OPD_P10,   OPD_T6,   OPD_P10};
            5'd24: u = '{ALU_SUB, OPD_P11,   OPD_T3,   OPD_P11};
            5'd25: u = '{ALU_MUL, OPD_T0,    OPD_T2,   OPD_T4};
            5'd26: u = '{ALU_ADD, OPD_ANGLE, OPD_T4,   OPD_ANGLE};
            5'd27: u = '{ALU_MUL, OPD_T1,    OPD_T2,   OPD_T4};
            5'd28: u = '{ALU_ADD, OPD_BIAS,  OPD_T4,   OPD_BIAS};
            5'd29: u = '{ALU_SUB, OPD_GYRO,  OPD_BIAS, OPD_T4};
            default: u = '{ALU_ADD, OPD_ZERO, OPD_ZERO, OPD_ZERO};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== src/kalman_tilt_angle_fuser_top.sv =====
// Top level of the two-state Kalman tilt angle fuser.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    measured_angle, gyro_rate
//   m_axis    out        m_axis_tvalid/m_axis_tready    angle, rate, bias estimates
//   cfg       in         i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
// Each sample uses the bit-serial multiplier (ten products) and the restoring divider
// (two gains); words are Q16.32 in 48 bits by default.
// Reset is synchronous and active low; it restores the settings and the filter state.
// A finished result waits in the output register while the next sample is taken in;
// if it is still waiting when the next update ends, the sequencer holds until it goes.
`timescale 1ns / 1ps
`default_nettype none
module kalman_tilt_angle_fuser_top
    import ktaf_pkg::*;
#(
    parameter int WORD_WIDTH = KT_WORD_WIDTH,
    parameter int FRAC_BITS  = KT_FRAC_BITS
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [CFG_ADDR_W-1:0]                  i_cfg_addr,
    input  wire  [CFG_W-1:0]                       i_cfg_wdata,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // measured_angle, gyro_rate, zero fill
    input  wire  [((2*WORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // angle_estimate, rate_estimate, bias_estimate, zero fill
    output logic [((3*WORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int W     = WORD_WIDTH;
    localparam int OUT_W = ((3*WORD_WIDTH+7)/8)*8;

    t_cmd         cmd;
    t_stat        stat;
    logic [W-1:0] angle, rate, bias;

    ktaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ktaf_dp #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_meas      (s_axis_tdata[W-1:0]),
        .i_gyro      (s_axis_tdata[2*W-1:W]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_angle     (angle),
        .o_rate      (rate),
        .o_bias      (bias)
    );

    assign m_axis_tdata = OUT_W'({bias, rate, angle});

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after a transfer");
    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> !s_axis_tready)
        else $error("datapath finished an operation while idle");
    a_no_done_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !stat.done)
        else $error("operation finished before it was issued");
`endif

endmodule
`default_nettype wire

// ===== src/ktaf_ctrl.sv =====
// Sequencer that walks the micro-op program and runs both stream handshakes.
`timescale 1ns / 1ps
`default_nettype none
module ktaf_ctrl
    import ktaf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_oval, n_oval;
    logic              emit_ok;

    assign emit_ok = !r_oval || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_oval  = r_oval && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_step  = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (i_stat.done) begin
                    if (r_step == LAST_STEP) begin
                        n_state = S_EMIT;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_oval  <= n_oval;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_oval;
    assign o_cmd.take_in    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.start      = (r_state == S_ISSUE);
    assign o_cmd.load_out   = (r_state == S_EMIT) && emit_ok;
    assign o_cmd.step       = r_step;

endmodule
`default_nettype wire

// ===== src/ktaf_dp.sv =====
// Datapath: filter state, settings, saturating adder, serial multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module ktaf_dp
    import ktaf_pkg::*;
#(
    parameter int WORD_WIDTH = KT_WORD_WIDTH,
    parameter int FRAC_BITS  = KT_FRAC_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [CFG_W-1:0]        i_cfg_wdata,
    input  wire  [WORD_WIDTH-1:0]   i_meas,
    input  wire  [WORD_WIDTH-1:0]   i_gyro,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [WORD_WIDTH-1:0]   o_angle,
    output logic [WORD_WIDTH-1:0]   o_rate,
    output logic [WORD_WIDTH-1:0]   o_bias
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F;
    localparam int MW = 2 * W + F;
    localparam int CW = $clog2(QW + 1);
    localparam int AW = CFG_W + 40;
    localparam int SR = (F <= CFG_W) ? CFG_W - F : 0;
    localparam int SL = (F > CFG_W) ? F - CFG_W : 0;
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_VAL = (F <= W - 2) ? (W'(1) << F) : WMAX;

    function automatic logic [W-1:0] sat_addsub(logic [W-1:0] a, logic [W-1:0] b,
                                                logic sub);
        logic [W:0] s;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag(logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Applies the sign to a magnitude and saturates to the word range.
    function automatic logic [W-1:0] finish(logic neg, logic [MW-1:0] m);
        logic [MW-1:0] lim;
        lim = MW'(WMAX) + MW'(neg);
        if (m > lim) begin
            return neg ? WMIN : WMAX;
        end
        return neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    endfunction

    function automatic logic [W-1:0] align_reg(logic [CFG_W-1:0] v);
        logic [AW-1:0] a;
        a = (AW'(v) >> SR) << SL;
        if (a > AW'(WMAX)) begin
            return WMAX;
        end
        return a[W-1:0];
    endfunction

    logic [CFG_W-1:0] r_qa_raw, r_qg_raw, r_rn_raw, r_dt_raw;
    logic [W-1:0] r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic [W-1:0] r_meas, r_gyro;
    logic [W-1:0] r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;

    logic          r_busy;
    t_alu          r_op;
    t_opnd         r_dst;
    logic [W-1:0]  r_a, r_b;
    logic          r_neg, r_num_zero, r_den_zero, r_num_neg;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_x;
    logic [W:0]    r_hi;
    logic [W-1:0]  r_lo;
    logic [W-1:0]  r_rem;
    logic [QW-1:0] r_q;

    t_uop          uop;
    logic [W-1:0]  va, vb, ma, mb, res;
    logic [W:0]    mul_sum, rem_sh;
    logic          fin;

    function automatic logic [W-1:0] pick(t_opnd s, logic [W-1:0] angle,
                                          logic [W-1:0] bias);
        logic [W-1:0] v;
        v = '0;
        unique case (s)
            OPD_ANGLE: v = angle;
            OPD_BIAS:  v = bias;
            OPD_P00:   v = r_p00;
            OPD_P01:   v = r_p01;
            OPD_P10:   v = r_p10;
            OPD_P11:   v = r_p11;
            OPD_MEAS:  v = r_meas;
            OPD_GYRO:  v = r_gyro;
            OPD_QA:    v = align_reg(r_qa_raw);
            OPD_QG:    v = align_reg(r_qg_raw);
            OPD_RN:    v = align_reg(r_rn_raw);
            OPD_DT:    v = align_reg(r_dt_raw);
            OPD_ZERO:  v = '0;
            OPD_T0:    v = r_t0;
            OPD_T1:    v = r_t1;
            OPD_T2:    v = r_t2;
            OPD_T3:    v = r_t3;
            OPD_T4:    v = r_t4;
            OPD_T5:    v = r_t5;
            OPD_T6:    v = r_t6;
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        uop     = prog_rom(i_cmd.step);
        va      = pick(uop.a, r_angle, r_bias);
        vb      = pick(uop.b, r_angle, r_bias);
        ma      = mag(va);
        mb      = mag(vb);
        mul_sum = r_hi + (r_lo[0] ? {1'b0, r_x} : '0);
        rem_sh  = {r_rem, r_q[QW-1]};
        fin     = r_busy && (r_cnt == '0);
        res     = '0;
        case (r_op)
            ALU_ADD: res = sat_addsub(r_a, r_b, 1'b0);
            ALU_SUB: res = sat_addsub(r_a, r_b, 1'b1);
            ALU_MUL: res = finish(r_neg, MW'({r_hi[W-1:0], r_lo} >> F));
            ALU_DIV: begin
                if (r_num_zero) begin
                    res = '0;
                end else if (r_den_zero) begin
                    res = r_num_neg ? WMIN : WMAX;
                end else begin
                    res = finish(r_neg, MW'(r_q));
                end
            end
            default: res = '0;
        endcase
    end

    assign o_stat.done = fin;

    // Settings and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa_raw <= RST_ANGLE_NOISE;
            r_qg_raw <= RST_BIAS_NOISE;
            r_rn_raw <= RST_MEAS_NOISE;
            r_dt_raw <= RST_PERIOD;
            r_angle  <= '0;
            r_bias   <= '0;
            r_p00    <= ONE_VAL;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= ONE_VAL;
            r_busy   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ANGLE_NOISE: r_qa_raw <= i_cfg_wdata;
                    CFG_BIAS_NOISE:  r_qg_raw <= i_cfg_wdata;
                    CFG_MEAS_NOISE:  r_rn_raw <= i_cfg_wdata;
                    CFG_PERIOD:      r_dt_raw <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (fin) begin
                r_busy <= 1'b0;
                case (r_dst)
                    OPD_ANGLE: r_angle <= res;
                    OPD_BIAS:  r_bias  <= res;
                    OPD_P00:   r_p00   <= res;
                    OPD_P01:   r_p01   <= res;
                    OPD_P10:   r_p10   <= res;
                    OPD_P11:   r_p11   <= res;
                    default: ;
                endcase
            end
        end
    end

    // Operands, temporaries, the iterating units and the output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_meas <= i_meas;
            r_gyro <= i_gyro;
        end
        if (i_cmd.start) begin
            r_op       <= uop.op;
            r_dst      <= uop.d;
            r_a        <= va;
            r_b        <= vb;
            r_neg      <= va[W-1] ^ vb[W-1];
            r_num_neg  <= va[W-1];
            r_num_zero <= (va == '0);
            r_den_zero <= (vb == '0);
            r_x        <= (uop.op == ALU_DIV) ? mb : ma;
            r_hi       <= '0;
            r_lo       <= mb;
            r_rem      <= '0;
            r_q        <= {ma, {F{1'b0}}};
            case (uop.op)
                ALU_MUL: r_cnt <= CW'(W);
                ALU_DIV: r_cnt <= ((va == '0) || (vb == '0)) ? '0 : CW'(QW);
                default: r_cnt <= '0;
            endcase
        end else if (r_busy && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_op == ALU_MUL) begin
                r_hi <= {1'b0, mul_sum[W:1]};
                r_lo <= {mul_sum[0], r_lo[W-1:1]};
            end else begin
                // The remainder stays below the divisor, so it fits in one word.
                if (rem_sh >= {1'b0, r_x}) begin
                    r_rem <= W'(rem_sh - {1'b0, r_x});
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[W-1:0];
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end
        end
        if (fin) begin
            case (r_dst)
                OPD_T0: r_t0 <= res;
                OPD_T1: r_t1 <= res;
                OPD_T2: r_t2 <= res;
                OPD_T3: r_t3 <= res;
                OPD_T4: r_t4 <= res;
                OPD_T5: r_t5 <= res;
                OPD_T6: r_t6 <= res;
                default: ;
            endcase
        end
        if (i_cmd.load_out) begin
            o_angle <= r_angle;
            o_rate  <= r_t4;
            o_bias  <= r_bias;
        end
    end

endmodule
`default_nettype wire
